// ===== rtl/core/ebiq_pkg.sv =====
// Shared types and constants for the encoder and button input qualifier.
// Holds the register map, button mode codes, quadrature table and the
// state, configuration and result structures. No dependencies.
package ebiq_pkg;

    // Configuration register map
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_DEB    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_DEB  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SHORT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIVIDER      = 3'd5;

    // Reset values of the registers
    localparam logic [15:0] RST_LONG_PRESS  = 16'd1000;
    localparam logic [7:0]  RST_PRESS_DEB   = 8'd20;
    localparam logic [7:0]  RST_RELEASE_DEB = 8'd30;
    localparam logic [15:0] RST_MIN_SHORT   = 16'd20;
    localparam logic [15:0] RST_TIMEOUT     = 16'd0;
    localparam logic [7:0]  RST_DIVIDER     = 8'd2;

    // Button mode codes
    localparam logic [2:0] MODE_IDLE       = 3'd0;
    localparam logic [2:0] MODE_DEBOUNCE   = 3'd1;
    localparam logic [2:0] MODE_HELD       = 3'd2;
    localparam logic [2:0] MODE_LONG_FIRED = 3'd3;
    localparam logic [2:0] MODE_RELEASE    = 3'd4;

    // Press event codes
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_SHORT = 2'd1;
    localparam logic [1:0] EV_LONG  = 2'd2;

    localparam logic signed [7:0] DETENT_UP   = 8'sd4;
    localparam logic signed [7:0] DETENT_DOWN = -8'sd4;
    localparam logic [15:0] HOLD_MAX     = 16'hFFFF;
    localparam logic [7:0]  DEBOUNCE_MAX = 8'hFF;

    // Step per transition, indexed by {previous phase, current phase}
    localparam logic signed [1:0] QUAD_TABLE [16] = '{
        2'sd0,  -2'sd1, 2'sd1,  2'sd0,
        2'sd1,  2'sd0,  2'sd0,  -2'sd1,
        -2'sd1, 2'sd0,  2'sd0,  2'sd1,
        2'sd0,  2'sd1,  -2'sd1, 2'sd0
    };

    typedef struct packed {
        logic [15:0] long_press_ticks;
        logic [7:0]  press_debounce_ticks;
        logic [7:0]  release_debounce_ticks;
        logic [15:0] min_short_ticks;
        logic [15:0] timeout_reload;
        logic [7:0]  countdown_divider;
    } ebiq_cfg_t;

    typedef struct packed {
        logic [1:0]  prev_phase;
        logic [7:0]  step_accumulator;
        logic [15:0] detent_count;
        logic [2:0]  button_mode;
        logic [7:0]  debounce_counter;
        logic [15:0] hold_counter;
        logic [7:0]  divider_counter;
        logic [15:0] countdown_value;
        logic        alive_flag;
    } ebiq_state_t;

    typedef struct packed {
        logic        pin_a;
        logic        pin_b;
        logic        button_level;
        logic        restart_countdown;
    } ebiq_in_t;

    typedef struct packed {
        logic signed [1:0]  detent_step;
        logic signed [15:0] position_count;
        logic [1:0]         press_event;
        logic [15:0]        hold_captured;
        logic               short_beep_req;
        logic               long_beep_req;
        logic               countdown_alive;
        logic               countdown_expired;
    } ebiq_result_t;

endpackage

// ===== rtl/core/ebiq_step.sv =====
// Next-state and result logic for one tick of the input qualifier.
// Purely combinational; depends on ebiq_pkg for its types and codes.
module ebiq_step
    import ebiq_pkg::*;
(
    input  ebiq_cfg_t    cfg,
    input  ebiq_state_t  cur,
    input  ebiq_in_t     item,
    output ebiq_state_t  nxt,
    output ebiq_result_t res
);

    always_comb
    begin
        logic [1:0]         phase;
        logic signed [1:0]  delta;
        logic signed [7:0]  acc;
        logic               activity;
        logic               btn_low;

        nxt = cur;
        res = '0;
        activity = 1'b0;
        btn_low = ~item.button_level;

        if (item.restart_countdown)
        begin
            nxt.countdown_value = cfg.timeout_reload;
            nxt.alive_flag      = 1'b1;
        end

        nxt.divider_counter = cur.divider_counter + 8'd1;
        if (nxt.divider_counter >= cfg.countdown_divider)
        begin
            nxt.divider_counter = '0;
            if (nxt.countdown_value != '0)
            begin
                nxt.countdown_value = nxt.countdown_value - 16'd1;
                if (nxt.countdown_value == '0)
                begin
                    nxt.alive_flag        = 1'b0;
                    res.countdown_expired = 1'b1;
                end
            end
        end

        phase = {item.pin_a, item.pin_b};
        delta = QUAD_TABLE[{cur.prev_phase, phase}];
        acc   = $signed(cur.step_accumulator) + {{6{delta[1]}}, delta};
        nxt.step_accumulator = acc;
        if (phase == 2'b00)
        begin
            if (acc >= DETENT_UP)
            begin
                nxt.detent_count     = cur.detent_count + 16'd1;
                nxt.step_accumulator = '0;
                res.detent_step      = 2'sd1;
                activity             = 1'b1;
            end
            else if (acc <= DETENT_DOWN)
            begin
                nxt.detent_count     = cur.detent_count - 16'd1;
                nxt.step_accumulator = '0;
                res.detent_step      = -2'sd1;
                activity             = 1'b1;
            end
        end
        nxt.prev_phase = phase;

        // A detent move reloads the countdown before the button is looked at,
        // so a confirmed press in the same tick reloads it to the same value.
        if (activity && cfg.timeout_reload != '0)
        begin
            nxt.countdown_value = cfg.timeout_reload;
            nxt.alive_flag      = 1'b1;
        end

        case (cur.button_mode)
            MODE_DEBOUNCE:
            begin
                if (btn_low)
                begin
                    if (cur.debounce_counter != DEBOUNCE_MAX)
                        nxt.debounce_counter = cur.debounce_counter + 8'd1;
                    if (nxt.debounce_counter >= cfg.press_debounce_ticks)
                    begin
                        nxt.button_mode    = MODE_HELD;
                        nxt.hold_counter   = '0;
                        res.short_beep_req = 1'b1;
                        if (cfg.timeout_reload != '0)
                        begin
                            nxt.countdown_value = cfg.timeout_reload;
                            nxt.alive_flag      = 1'b1;
                        end
                    end
                end
                else
                begin
                    nxt.button_mode = MODE_IDLE;
                end
            end
            MODE_HELD:
            begin
                if (btn_low)
                begin
                    if (cur.hold_counter != HOLD_MAX)
                        nxt.hold_counter = cur.hold_counter + 16'd1;
                    if (nxt.hold_counter >= cfg.long_press_ticks)
                    begin
                        res.press_event   = EV_LONG;
                        res.hold_captured = nxt.hold_counter;
                        res.long_beep_req = 1'b1;
                        nxt.button_mode   = MODE_LONG_FIRED;
                    end
                end
                else
                begin
                    if (cur.hold_counter >= cfg.min_short_ticks)
                    begin
                        res.press_event   = EV_SHORT;
                        res.hold_captured = cur.hold_counter;
                    end
                    nxt.debounce_counter = '0;
                    nxt.button_mode      = MODE_RELEASE;
                end
            end
            MODE_LONG_FIRED:
            begin
                if (!btn_low)
                begin
                    nxt.debounce_counter = '0;
                    nxt.button_mode      = MODE_RELEASE;
                end
            end
            MODE_RELEASE:
            begin
                if (!btn_low)
                begin
                    if (cur.debounce_counter != DEBOUNCE_MAX)
                        nxt.debounce_counter = cur.debounce_counter + 8'd1;
                    if (nxt.debounce_counter >= cfg.release_debounce_ticks)
                    begin
                        nxt.hold_counter = '0;
                        nxt.button_mode  = MODE_IDLE;
                    end
                end
                else
                begin
                    nxt.debounce_counter = '0;
                end
            end
            default:
            begin
                if (btn_low)
                begin
                    nxt.debounce_counter = '0;
                    nxt.button_mode      = MODE_DEBOUNCE;
                end
                else
                begin
                    nxt.button_mode = MODE_IDLE;
                end
            end
        endcase

        res.position_count  = $signed(nxt.detent_count);
        res.countdown_alive = nxt.alive_flag;
    end

endmodule

// ===== rtl/core/encoder_button_input_qualifier.sv =====
// Encoder and button input qualifier: top level with the register file,
// input and result registers and the tick state. Uses ebiq_pkg and ebiq_step.
//
// Each word on the input stream is one tick: encoder pins A and B, the
// active-low button and a countdown restart request. Each accepted word
// yields exactly one result word, in order. A word is taken into an input
// register; once the result register is free or being emptied, the
// combinational step logic updates the tick state and loads the result
// register, from which the result is presented. One word can be accepted
// every clock cycle; the input register refills while a result waits, and
// the input side only stalls when both registers are full and the result
// is not taken. Registers are written through the configuration channel,
// which is always ready; write them only while no word is in flight.
module encoder_button_input_qualifier
    import ebiq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // bit 0 pin_a, bit 1 pin_b, bit 2 button_level, bit 3 restart_countdown,
    // bits 7:4 zero
    input  logic [7:0]           s_tdata,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [1:0] detent_step, [17:2] position_count, [19:18] press_event,
    // [35:20] hold_captured, [36] short_beep_req, [37] long_beep_req,
    // [38] countdown_alive, [39] countdown_expired
    output logic [39:0]          m_tdata
);

    // Tick state after reset: everything clear, button idle, countdown alive.
    localparam ebiq_state_t STATE_RESET = '{2'd0, 8'd0, 16'd0, MODE_IDLE, 8'd0,
                                            16'd0, 8'd0, 16'd0, 1'b1};

    ebiq_cfg_t    cfg_reg;
    ebiq_state_t  state_reg;
    ebiq_state_t  state_next;
    ebiq_in_t     in_data_reg;
    ebiq_result_t res_next;
    ebiq_result_t out_data_reg;
    logic         in_vld_reg;
    logic         out_vld_reg;
    logic         fire;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ticks       <= RST_LONG_PRESS;
            cfg_reg.press_debounce_ticks   <= RST_PRESS_DEB;
            cfg_reg.release_debounce_ticks <= RST_RELEASE_DEB;
            cfg_reg.min_short_ticks        <= RST_MIN_SHORT;
            cfg_reg.timeout_reload         <= RST_TIMEOUT;
            cfg_reg.countdown_divider      <= RST_DIVIDER;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_LONG_PRESS:  cfg_reg.long_press_ticks       <= cfg_data;
                REG_PRESS_DEB:   cfg_reg.press_debounce_ticks   <= cfg_data[7:0];
                REG_RELEASE_DEB: cfg_reg.release_debounce_ticks <= cfg_data[7:0];
                REG_MIN_SHORT:   cfg_reg.min_short_ticks        <= cfg_data;
                REG_TIMEOUT:     cfg_reg.timeout_reload         <= cfg_data;
                REG_DIVIDER:     cfg_reg.countdown_divider      <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    // The step runs whenever a tick is waiting and the result register is
    // free or being emptied in this cycle.
    assign fire     = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_vld_reg <= s_tvalid;
            if (fire)
                out_vld_reg <= 1'b1;
            else if (m_tready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg.pin_a             <= s_tdata[0];
            in_data_reg.pin_b             <= s_tdata[1];
            in_data_reg.button_level      <= s_tdata[2];
            in_data_reg.restart_countdown <= s_tdata[3];
        end
        if (fire)
            out_data_reg <= res_next;
    end

    ebiq_step u_step (
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .item (in_data_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_data_reg.countdown_expired,
                       out_data_reg.countdown_alive,
                       out_data_reg.long_beep_req,
                       out_data_reg.short_beep_req,
                       out_data_reg.hold_captured,
                       out_data_reg.press_event,
                       out_data_reg.position_count,
                       out_data_reg.detent_step};

    // A processed tick always lands in the result register.
    assert property (@(posedge clk) disable iff (!rst_n) fire |=> out_vld_reg)
        else $error("processed word did not reach the result register");

    // The input side only stalls with both registers occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_vld_reg && out_vld_reg && !m_tready))
        else $error("input stalled while a register was free");

    // The tick state moves only when a tick is processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(state_reg.detent_count) && $stable(state_reg.hold_counter))
        else $error("tick state changed without a processed word");

    // Hold time is cleared before the button machine returns to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.button_mode == MODE_IDLE || state_reg.button_mode == MODE_DEBOUNCE)
        |-> (state_reg.hold_counter == '0))
        else $error("hold counter not cleared outside a press");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking bench for the encoder and button input qualifier: tick words
// are streamed in, each result word is checked against a tick-by-tick predictor.
// Depends on ebiq_pkg and encoder_button_input_qualifier only.
module tb_top;
    import ebiq_pkg::*;

    localparam int PHASE_TICKS    = 230;
    localparam int STAGE_COUNT    = 8;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 4000;

    // Opening sequence, one nibble per tick: {restart, button, pin_b, pin_a}.
    localparam logic [3:0] OPENING_TICKS [21] = '{
        4'b1101, 4'b0011, 4'b0010, 4'b0000, 4'b0001, 4'b0011, 4'b0110,
        4'b0100, 4'b0010, 4'b0011, 4'b0001, 4'b0000, 4'b0100, 4'b0100,
        4'b0000, 4'b0000, 4'b0100, 4'b0100, 4'b0111, 4'b0100, 4'b1100
    };

    // Quadrature phases {A, B} in clockwise order.
    localparam logic [1:0] CW_PHASES [4] = '{2'd0, 2'd2, 2'd3, 2'd1};

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [39:0]          m_tdata;

    // Predictor copy of the registers and the tick state
    ebiq_cfg_t         regs = '{RST_LONG_PRESS, RST_PRESS_DEB, RST_RELEASE_DEB,
                                RST_MIN_SHORT, RST_TIMEOUT, RST_DIVIDER};
    logic [1:0]        last_phase = '0;
    logic signed [7:0] accum = '0;
    logic [15:0]       detents = '0;
    logic [2:0]        mode = MODE_IDLE;
    logic [7:0]        deb_count = '0;
    logic [15:0]       hold_count = '0;
    logic [7:0]        div_count = '0;
    logic [15:0]       cd_value = '0;
    logic              alive = 1'b1;

    ebiq_in_t     tick_queue [$];
    ebiq_result_t pending_results [$];
    int           ticks_in_flight = 0;
    logic         tick_taken = 1'b0;
    logic         reg_taken = 1'b0;
    int           send_gap = 0;
    int           tx_quiet = 0;
    int           rx_stall = 0;
    int           rx_quiet = 0;
    int           idle_cycles = 0;
    int           errors = 0;

    // Stimulus generator state
    logic [1:0]   enc_pos = '0;
    logic         enc_cw = 1'b1;
    logic         btn_level = 1'b1;
    int           btn_left = 0;

    // Coverage tallies for the summary
    int           ticks_sent = 0;
    int           words_checked = 0;
    int           settings_used = 0;
    int           moves_up = 0;
    int           moves_down = 0;
    int           short_presses = 0;
    int           long_presses = 0;
    int           expiries = 0;

    encoder_button_input_qualifier uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Mostly back-to-back, some short gaps, a few long ones, and now and then
    // a quiet stretch of 50 to 200 picks with no gaps at all.
    function automatic int pick_gap(inout int quiet);
        int r;
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r == 0)
            quiet = $urandom_range(50, 200);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void refresh_countdown();
        if (regs.timeout_reload != 16'd0)
        begin
            cd_value = regs.timeout_reload;
            alive = 1'b1;
        end
    endfunction

    function automatic ebiq_result_t qualify_tick(logic a, logic b, logic btn,
                                                  logic restart);
        ebiq_result_t r;
        logic [1:0]   ph;
        r = '0;
        if (restart)
        begin
            cd_value = regs.timeout_reload;
            alive = 1'b1;
        end

        div_count = div_count + 8'd1;
        if (div_count >= regs.countdown_divider)
        begin
            div_count = '0;
            if (cd_value != 16'd0)
            begin
                cd_value = cd_value - 16'd1;
                if (cd_value == 16'd0)
                begin
                    alive = 1'b0;
                    r.countdown_expired = 1'b1;
                end
            end
        end

        ph = {a, b};
        accum = accum + 8'(QUAD_TABLE[{last_phase, ph}]);
        if (ph == 2'd0)
        begin
            if (accum >= DETENT_UP)
            begin
                detents = detents + 16'd1;
                accum = '0;
                r.detent_step = 2'sd1;
                refresh_countdown();
            end
            else if (accum <= DETENT_DOWN)
            begin
                detents = detents - 16'd1;
                accum = '0;
                r.detent_step = -2'sd1;
                refresh_countdown();
            end
        end
        last_phase = ph;

        case (mode)
            MODE_DEBOUNCE:
            begin
                if (!btn)
                begin
                    if (deb_count != DEBOUNCE_MAX)
                        deb_count = deb_count + 8'd1;
                    if (deb_count >= regs.press_debounce_ticks)
                    begin
                        mode = MODE_HELD;
                        hold_count = '0;
                        r.short_beep_req = 1'b1;
                        refresh_countdown();
                    end
                end
                else
                    mode = MODE_IDLE;
            end
            MODE_HELD:
            begin
                if (!btn)
                begin
                    if (hold_count != HOLD_MAX)
                        hold_count = hold_count + 16'd1;
                    if (hold_count >= regs.long_press_ticks)
                    begin
                        r.press_event = EV_LONG;
                        r.hold_captured = hold_count;
                        r.long_beep_req = 1'b1;
                        mode = MODE_LONG_FIRED;
                    end
                end
                else
                begin
                    if (hold_count >= regs.min_short_ticks)
                    begin
                        r.press_event = EV_SHORT;
                        r.hold_captured = hold_count;
                    end
                    deb_count = '0;
                    mode = MODE_RELEASE;
                end
            end
            MODE_LONG_FIRED:
            begin
                if (btn)
                begin
                    deb_count = '0;
                    mode = MODE_RELEASE;
                end
            end
            MODE_RELEASE:
            begin
                if (btn)
                begin
                    if (deb_count != DEBOUNCE_MAX)
                        deb_count = deb_count + 8'd1;
                    if (deb_count >= regs.release_debounce_ticks)
                    begin
                        hold_count = '0;
                        mode = MODE_IDLE;
                    end
                end
                else
                    deb_count = '0;
            end
            default:
            begin
                if (!btn)
                begin
                    deb_count = '0;
                    mode = MODE_DEBOUNCE;
                end
                else
                    mode = MODE_IDLE;
            end
        endcase

        r.position_count = detents;
        r.countdown_alive = alive;
        return r;
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
        case (idx)
            REG_LONG_PRESS:  regs.long_press_ticks = value;
            REG_PRESS_DEB:   regs.press_debounce_ticks = value[7:0];
            REG_RELEASE_DEB: regs.release_debounce_ticks = value[7:0];
            REG_MIN_SHORT:   regs.min_short_ticks = value;
            REG_TIMEOUT:     regs.timeout_reload = value;
            REG_DIVIDER:     regs.countdown_divider = value[7:0];
            default:         ;
        endcase
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function automatic void check_result(logic [39:0] d);
        ebiq_result_t e;
        if (pending_results.size() == 0)
        begin
            $error("result word arrived with no tick waiting for it");
            errors++;
            return;
        end
        e = pending_results.pop_front();
        check_field("detent_step", int'($signed(e.detent_step)), int'($signed(d[1:0])));
        check_field("position_count", int'($signed(e.position_count)),
                    int'($signed(d[17:2])));
        check_field("press_event", int'(e.press_event), int'(d[19:18]));
        check_field("hold_captured", int'(e.hold_captured), int'(d[35:20]));
        check_field("short_beep_req", int'(e.short_beep_req), int'(d[36]));
        check_field("long_beep_req", int'(e.long_beep_req), int'(d[37]));
        check_field("countdown_alive", int'(e.countdown_alive), int'(d[38]));
        check_field("countdown_expired", int'(e.countdown_expired), int'(d[39]));
        words_checked++;
        if (e.detent_step == 2'sd1)
            moves_up++;
        if (e.detent_step == -2'sd1)
            moves_down++;
        if (e.press_event == EV_SHORT)
            short_presses++;
        if (e.press_event == EV_LONG)
            long_presses++;
        if (e.countdown_expired)
            expiries++;
    endfunction

    // Sampling side: registers, accepted ticks and result words at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
            reg_taken <= cfg_valid && cfg_ready;
            if (s_tvalid && s_tready)
            begin
                pending_results.push_back(qualify_tick(s_tdata[0], s_tdata[1],
                                                       s_tdata[2], s_tdata[3]));
                ticks_in_flight--;
                ticks_sent++;
            end
            tick_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
                check_result(m_tdata);
        end
    end

    // Tick driver: a new word goes out once the previous one is taken and its gap has run.
    always @(negedge clk)
    begin
        if (rst_n && (tick_taken || !s_tvalid))
        begin
            if (send_gap > 0)
            begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (tick_queue.size() > 0)
            begin
                ebiq_in_t t;
                t = tick_queue.pop_front();
                s_tdata <= {4'b0000, t.restart_countdown, t.button_level, t.pin_b, t.pin_a};
                s_tvalid <= 1'b1;
                send_gap <= pick_gap(tx_quiet);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result receiver with random back-pressure.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_stall > 0)
            begin
                m_tready <= 1'b0;
                rx_stall <= rx_stall - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                rx_stall <= pick_gap(rx_quiet);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** encoder_button_input_qualifier: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(negedge clk);
        while (!reg_taken);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic [15:0] long_press, input logic [7:0] press_deb,
                                  input logic [7:0] release_deb, input logic [15:0] min_short,
                                  input logic [15:0] timeout, input logic [7:0] divider);
        write_reg(REG_LONG_PRESS, long_press);
        write_reg(REG_PRESS_DEB, {8'd0, press_deb});
        write_reg(REG_RELEASE_DEB, {8'd0, release_deb});
        write_reg(REG_MIN_SHORT, min_short);
        write_reg(REG_TIMEOUT, timeout);
        write_reg(REG_DIVIDER, {8'd0, divider});
        settings_used++;
    endtask

    task automatic queue_tick(input logic [3:0] nibble);
        ebiq_in_t t;
        t.pin_a = nibble[0];
        t.pin_b = nibble[1];
        t.button_level = nibble[2];
        t.restart_countdown = nibble[3];
        tick_queue.push_back(t);
        ticks_in_flight++;
    endtask

    // Hold lengths aim at the bounce, minimum-short and long-press boundaries.
    function automatic int press_len();
        int pd;
        int n;
        pd = regs.press_debounce_ticks;
        case ($urandom_range(0, 9))
            0:          n = $urandom_range(1, pd);
            1, 2, 3, 4: n = pd + 1 + $urandom_range(0, regs.min_short_ticks + 4);
            5, 6, 7:    n = pd + regs.long_press_ticks + $urandom_range(0, 2);
            default:    n = $urandom_range(1, 40);
        endcase
        if (n > 300)
            n = $urandom_range(pd + 1, 300);
        return n;
    endfunction

    function automatic int release_len();
        int rd;
        rd = regs.release_debounce_ticks;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(1, rd);
        return rd + 1 + $urandom_range(0, 12);
    endfunction

    // Mostly clean rotation and whole press-hold-release runs, with a little noise.
    task automatic queue_random(input int count);
        logic [1:0] ph;
        int         r;
        repeat (count)
        begin
            r = $urandom_range(0, 15);
            if (r == 0)
                enc_cw = !enc_cw;
            else if (r >= 4)
                enc_pos = enc_cw ? enc_pos + 2'd1 : enc_pos - 2'd1;
            ph = (r == 1) ? 2'($urandom) : CW_PHASES[enc_pos];
            if (btn_left == 0)
            begin
                btn_level = !btn_level;
                btn_left = btn_level ? release_len() : press_len();
            end
            btn_left--;
            queue_tick({$urandom_range(0, 39) == 0, btn_level, ph[0], ph[1]});
        end
    endtask

    task automatic wait_idle();
        while (ticks_in_flight != 0 || pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int stage;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Tight thresholds so that every button outcome, both rotation
        // directions and an expiry coinciding with a reload fit in a few ticks.
        apply_settings(16'd3, 8'd1, 8'd1, 16'd2, 16'd4, 8'd1);
        foreach (OPENING_TICKS[i])
            queue_tick(OPENING_TICKS[i]);
        wait_idle();

        for (stage = 0; stage < STAGE_COUNT; stage++)
        begin
            case (stage)
                0: apply_settings(16'd1, 8'd1, 8'd1, 16'd0, 16'd1, 8'd1);
                1: apply_settings(HOLD_MAX, DEBOUNCE_MAX, DEBOUNCE_MAX, HOLD_MAX, HOLD_MAX,
                                  DEBOUNCE_MAX);
                2: apply_settings(RST_LONG_PRESS, RST_PRESS_DEB, RST_RELEASE_DEB,
                                  RST_MIN_SHORT, RST_TIMEOUT, RST_DIVIDER);
                default:
                    apply_settings(16'($urandom_range(1, 80)), 8'($urandom_range(1, 8)),
                                   8'($urandom_range(1, 8)), 16'($urandom_range(0, 40)),
                                   ($urandom_range(0, 3) == 0) ? 16'd0
                                                               : 16'($urandom_range(1, 60)),
                                   8'($urandom_range(1, 6)));
            endcase
            if (stage == 3)
            begin
                // Sender holds off mid-stage until every result word is back.
                queue_random(PHASE_TICKS / 2);
                wait_idle();
                queue_random(PHASE_TICKS - PHASE_TICKS / 2);
            end
            else
                queue_random(PHASE_TICKS);
            wait_idle();
        end

        $display("Checked %0d result words from %0d ticks under %0d register settings.",
                 words_checked, ticks_sent, settings_used);
        $display("Seen %0d detents up, %0d down, %0d short and %0d long presses, %0d expiries.",
                 moves_up, moves_down, short_presses, long_presses, expiries);
        if (errors == 0 && pending_results.size() == 0)
            $display("** encoder_button_input_qualifier: PASSED **");
        else
            $display("** encoder_button_input_qualifier: FAILED **");
        $finish;
    end

endmodule

// ===== encoder_button_input_qualifier.f =====
rtl/core/ebiq_pkg.sv
rtl/core/ebiq_step.sv
rtl/core/encoder_button_input_qualifier.sv
dv/tb_top.sv
